// ===== rtl/core/mtc_pkg.sv =====
// shared types and constants for the midi time code tracker
// no dependencies; every other file of the block but the checker uses this package
package mtc_pkg;

  // field widths
  localparam int FPS_W     = 6;
  localparam int TC_W      = 8;
  localparam int HOURS_W   = 5;
  localparam int RATE_W    = 2;
  localparam int SX_W      = 7;
  localparam int KIND_W    = 2;
  localparam int PART_W    = 3;
  localparam int NIB_W     = 4;
  localparam int NUM_PARTS = 8;
  localparam int NUM_RATES = 4;
  localparam int CFG_IDX_W = 2;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_QF   = 2'd0,
    KIND_FULL = 2'd1,
    KIND_TICK = 2'd2
  } kind_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FPS_RATE0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FPS_RATE1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FPS_RATE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FPS_RATE3 = 2'd3;

  // configuration reset values
  localparam logic [FPS_W-1:0] FPS_RST0 = 6'd24;
  localparam logic [FPS_W-1:0] FPS_RST1 = 6'd25;
  localparam logic [FPS_W-1:0] FPS_RST2 = 6'd30;
  localparam logic [FPS_W-1:0] FPS_RST3 = 6'd30;

  // full-frame header bytes
  localparam logic [SX_W-1:0] SX_DEVICE_ALL = 7'h7F;
  localparam logic [SX_W-1:0] SX_ID_MTC     = 7'h7F;
  localparam logic [SX_W-1:0] SX_ID_FULL    = 7'h01;

  // time code wrap points
  localparam logic [TC_W-1:0]    SEC_WRAP  = 8'd60;
  localparam logic [TC_W-1:0]    MIN_WRAP  = 8'd60;
  localparam logic [TC_W-1:0]    SEC_LAST  = 8'd59;
  localparam logic [TC_W-1:0]    MIN_LAST  = 8'd59;
  localparam logic [HOURS_W-1:0] HOUR_WRAP = 5'd24;
  localparam logic [HOURS_W-1:0] HOUR_LAST = 5'd23;
  localparam logic [PART_W-1:0]  PART_LAST = 3'd7;
  localparam logic [PART_W-1:0]  PART_FIRST = 3'd0;
  localparam logic [TC_W-1:0]    TICK_MAX  = 8'hFF;
  localparam logic [TC_W-1:0]    JUMP_MIN  = 8'd2;

  typedef logic [NUM_RATES-1:0][FPS_W-1:0] fps_tab_t;

  // one input word
  typedef struct packed {
    logic [KIND_W-1:0] func;
    logic [SX_W-1:0]   qf_byte;
    logic [SX_W-1:0]   sx_device;
    logic [SX_W-1:0]   sx_sub_id1;
    logic [SX_W-1:0]   sx_sub_id2;
    logic [SX_W-1:0]   sx_rate_hours;
    logic [SX_W-1:0]   sx_minutes;
    logic [SX_W-1:0]   sx_seconds;
    logic [SX_W-1:0]   sx_frames;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic               update_valid;
    logic [TC_W-1:0]    frames;
    logic [TC_W-1:0]    seconds;
    logic [TC_W-1:0]    minutes;
    logic [HOURS_W-1:0] hours;
    logic [RATE_W-1:0]  rate;
    logic               forward;
    logic               timer_restart;
  } res_t;

endpackage

// ===== rtl/core/mtc_if.sv =====
// valid/ready channel interfaces for the input and result words
// depends on mtc_pkg for the field widths
interface mtc_in_if;
  logic                      valid;
  logic                      ready;
  logic [mtc_pkg::KIND_W-1:0] func;
  logic [mtc_pkg::SX_W-1:0]  qf_byte;
  logic [mtc_pkg::SX_W-1:0]  sx_device;
  logic [mtc_pkg::SX_W-1:0]  sx_sub_id1;
  logic [mtc_pkg::SX_W-1:0]  sx_sub_id2;
  logic [mtc_pkg::SX_W-1:0]  sx_rate_hours;
  logic [mtc_pkg::SX_W-1:0]  sx_minutes;
  logic [mtc_pkg::SX_W-1:0]  sx_seconds;
  logic [mtc_pkg::SX_W-1:0]  sx_frames;

  modport source(output valid, func, qf_byte, sx_device, sx_sub_id1, sx_sub_id2,
                 sx_rate_hours, sx_minutes, sx_seconds, sx_frames,
                 input ready);
  modport sink(input valid, func, qf_byte, sx_device, sx_sub_id1, sx_sub_id2,
               sx_rate_hours, sx_minutes, sx_seconds, sx_frames,
               output ready);
endinterface

interface mtc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         update_valid;
  logic [mtc_pkg::TC_W-1:0]     out_frames;
  logic [mtc_pkg::TC_W-1:0]     out_seconds;
  logic [mtc_pkg::TC_W-1:0]     out_minutes;
  logic [mtc_pkg::HOURS_W-1:0]  out_hours;
  logic [mtc_pkg::RATE_W-1:0]   out_rate;
  logic                         out_forward;
  logic                         timer_restart;

  modport source(output valid, update_valid, out_frames, out_seconds, out_minutes,
                 out_hours, out_rate, out_forward, timer_restart,
                 input ready);
  modport sink(input valid, update_valid, out_frames, out_seconds, out_minutes,
               out_hours, out_rate, out_forward, timer_restart,
               output ready);
endinterface

// ===== rtl/core/mtc_cfg.sv =====
// frames-per-second registers, one per rate type
// depends on mtc_pkg
module mtc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mtc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mtc_pkg::FPS_W-1:0]     cfg_wdata,
  output mtc_pkg::fps_tab_t             fps_tab
);
  import mtc_pkg::*;

  fps_tab_t fps_r;
  fps_tab_t fps_nxt;

  // register write decode
  always_comb begin
    fps_nxt = fps_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FPS_RATE0: fps_nxt[0] = cfg_wdata;
        REG_FPS_RATE1: fps_nxt[1] = cfg_wdata;
        REG_FPS_RATE2: fps_nxt[2] = cfg_wdata;
        REG_FPS_RATE3: fps_nxt[3] = cfg_wdata;
        default:       fps_nxt = fps_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fps_r[0] <= FPS_RST0;
      fps_r[1] <= FPS_RST1;
      fps_r[2] <= FPS_RST2;
      fps_r[3] <= FPS_RST3;
    end else begin
      fps_r <= fps_nxt;
    end
  end

  assign fps_tab = fps_r;

endmodule

// ===== rtl/core/mtc_track.sv =====
// time code state and the per-word update: quarter frames, full frames, ticks
// depends on mtc_pkg; the state advances when fire is high
module mtc_track (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  mtc_pkg::in_word_t word,
  input  mtc_pkg::fps_tab_t fps_tab,
  output mtc_pkg::res_t     res
);
  import mtc_pkg::*;

  // state
  logic [NUM_PARTS-1:0][NIB_W-1:0] nib_r, nib_nxt;
  logic [PART_W-1:0]  last_part_r, last_part_nxt;
  logic               forward_r, forward_nxt;
  logic [TC_W-1:0]    frames_r, frames_nxt;
  logic [TC_W-1:0]    seconds_r, seconds_nxt;
  logic [TC_W-1:0]    minutes_r, minutes_nxt;
  logic [HOURS_W-1:0] hours_r, hours_nxt;
  logic [RATE_W-1:0]  rate_r, rate_nxt;
  logic [TC_W-1:0]    prior_r, prior_nxt;
  logic [TC_W-1:0]    jump_r, jump_nxt;
  logic [TC_W-1:0]    ticks_r, ticks_nxt;

  // quarter-frame decode
  logic [PART_W-1:0]  qf_part;
  logic [NIB_W-1:0]   qf_nib;
  logic [NUM_PARTS-1:0][NIB_W-1:0] qf_nibs;
  logic               qf_fwd;
  logic               qf_boundary;
  logic [TC_W-1:0]    asm_frames, asm_seconds, asm_minutes;
  logic [HOURS_W-1:0] asm_hours;
  logic [RATE_W-1:0]  asm_rate;
  logic [TC_W-1:0]    asm_diff;
  logic [TC_W-1:0]    asm_jump;
  logic [FPS_W-1:0]   asm_fps;

  // tick step
  logic [FPS_W-1:0]   tk_fps;
  logic [TC_W-1:0]    tk_fps8;
  logic [TC_W-1:0]    fr_inc, sec_inc, min_inc;
  logic [HOURS_W-1:0] hr_inc;
  logic [TC_W-1:0]    fw_frames, fw_seconds, fw_minutes;
  logic [HOURS_W-1:0] fw_hours;
  logic [TC_W-1:0]    rv_frames, rv_seconds, rv_minutes;
  logic [HOURS_W-1:0] rv_hours;

  logic               sx_ok;
  logic               upd;
  logic               restart;

  // quarter frame: store nibble, learn direction, assemble at the boundary
  always_comb begin
    qf_part = word.qf_byte[6:4];
    qf_nib  = word.qf_byte[3:0];
    qf_nibs = nib_r;
    qf_nibs[qf_part] = qf_nib;
    if (qf_part != PART_LAST && last_part_r != PART_LAST) begin
      qf_fwd = last_part_r < qf_part;
    end else begin
      qf_fwd = forward_r;
    end
    qf_boundary = (qf_fwd && qf_part == PART_LAST) || (!qf_fwd && qf_part == PART_FIRST);
    asm_frames  = {qf_nibs[1], qf_nibs[0]};
    asm_seconds = {qf_nibs[3], qf_nibs[2]};
    asm_minutes = {qf_nibs[5], qf_nibs[4]};
    asm_hours   = {qf_nibs[7][0], qf_nibs[6]};
    asm_rate    = qf_nibs[7][2:1];
    asm_diff    = (asm_frames < prior_r) ? (prior_r - asm_frames) : (asm_frames - prior_r);
    asm_fps     = fps_tab[asm_rate];
    if (({1'b0, asm_diff} + 9'd2) >= {3'b000, asm_fps}) begin
      asm_jump = JUMP_MIN;
    end else begin
      asm_jump = asm_diff;
    end
  end

  // one frame forward with carry, one frame back with borrow
  always_comb begin
    tk_fps  = fps_tab[rate_r];
    tk_fps8 = {2'b00, tk_fps};
    fr_inc  = frames_r + 8'd1;
    sec_inc = seconds_r + 8'd1;
    min_inc = minutes_r + 8'd1;
    hr_inc  = hours_r + 5'd1;

    fw_frames  = fr_inc;
    fw_seconds = seconds_r;
    fw_minutes = minutes_r;
    fw_hours   = hours_r;
    if (fr_inc == tk_fps8) begin
      fw_frames  = '0;
      fw_seconds = sec_inc;
      if (sec_inc == SEC_WRAP) begin
        fw_seconds = '0;
        fw_minutes = min_inc;
        if (min_inc == MIN_WRAP) begin
          fw_minutes = '0;
          fw_hours   = (hr_inc == HOUR_WRAP) ? '0 : hr_inc;
        end
      end
    end

    rv_frames  = frames_r - 8'd1;
    rv_seconds = seconds_r;
    rv_minutes = minutes_r;
    rv_hours   = hours_r;
    if (frames_r == '0) begin
      rv_frames  = tk_fps8 - 8'd1;
      rv_seconds = seconds_r - 8'd1;
      if (seconds_r == '0) begin
        rv_seconds = SEC_LAST;
        rv_minutes = minutes_r - 8'd1;
        if (minutes_r == '0) begin
          rv_minutes = MIN_LAST;
          rv_hours   = (hours_r == '0) ? HOUR_LAST : (hours_r - 5'd1);
        end
      end
    end
  end

  assign sx_ok = word.sx_device == SX_DEVICE_ALL && word.sx_sub_id1 == SX_ID_MTC &&
                 word.sx_sub_id2 == SX_ID_FULL;

  // next state by item kind
  always_comb begin
    nib_nxt       = nib_r;
    last_part_nxt = last_part_r;
    forward_nxt   = forward_r;
    frames_nxt    = frames_r;
    seconds_nxt   = seconds_r;
    minutes_nxt   = minutes_r;
    hours_nxt     = hours_r;
    rate_nxt      = rate_r;
    prior_nxt     = prior_r;
    jump_nxt      = jump_r;
    ticks_nxt     = ticks_r;
    upd           = 1'b0;
    restart       = 1'b0;
    unique case (word.func)
      KIND_QF: begin
        nib_nxt       = qf_nibs;
        forward_nxt   = qf_fwd;
        last_part_nxt = qf_part;
        if (qf_boundary) begin
          frames_nxt  = asm_frames;
          seconds_nxt = asm_seconds;
          minutes_nxt = asm_minutes;
          hours_nxt   = asm_hours;
          rate_nxt    = asm_rate;
          prior_nxt   = asm_frames;
          jump_nxt    = asm_jump;
          upd         = ticks_r < asm_jump;
          restart     = 1'b1;
          ticks_nxt   = '0;
        end
      end
      KIND_FULL: begin
        if (sx_ok) begin
          frames_nxt  = {1'b0, word.sx_frames};
          seconds_nxt = {1'b0, word.sx_seconds};
          minutes_nxt = {1'b0, word.sx_minutes};
          hours_nxt   = word.sx_rate_hours[4:0];
          rate_nxt    = word.sx_rate_hours[6:5];
          upd         = 1'b1;
          ticks_nxt   = '0;
        end
      end
      KIND_TICK: begin
        if (ticks_r != TICK_MAX) begin
          ticks_nxt = ticks_r + 8'd1;
        end
        if (forward_r) begin
          frames_nxt  = fw_frames;
          seconds_nxt = fw_seconds;
          minutes_nxt = fw_minutes;
          hours_nxt   = fw_hours;
        end else begin
          frames_nxt  = rv_frames;
          seconds_nxt = rv_seconds;
          minutes_nxt = rv_minutes;
          hours_nxt   = rv_hours;
        end
        upd = 1'b1;
        if (jump_r == JUMP_MIN) begin
          jump_nxt = '0;
          restart  = 1'b1;
        end
      end
      default: begin
        upd = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nib_r       <= '0;
      last_part_r <= '0;
      forward_r   <= 1'b0;
      frames_r    <= '0;
      seconds_r   <= '0;
      minutes_r   <= '0;
      hours_r     <= '0;
      rate_r      <= '0;
      prior_r     <= '0;
      jump_r      <= '0;
      ticks_r     <= '0;
    end else if (fire) begin
      nib_r       <= nib_nxt;
      last_part_r <= last_part_nxt;
      forward_r   <= forward_nxt;
      frames_r    <= frames_nxt;
      seconds_r   <= seconds_nxt;
      minutes_r   <= minutes_nxt;
      hours_r     <= hours_nxt;
      rate_r      <= rate_nxt;
      prior_r     <= prior_nxt;
      jump_r      <= jump_nxt;
      ticks_r     <= ticks_nxt;
    end
  end

  // result shows the state after this word
  always_comb begin
    res.update_valid  = upd;
    res.frames        = frames_nxt;
    res.seconds       = seconds_nxt;
    res.minutes       = minutes_nxt;
    res.hours         = hours_nxt;
    res.rate          = rate_nxt;
    res.forward       = forward_nxt;
    res.timer_restart = restart;
  end

endmodule

// ===== rtl/core/midi_timecode_tracker_core.sv =====
// MIDI time code tracker: follows quarter frames, full-frame messages and frame ticks and
// reports the current time after every word. A taken word waits in the input register and
// is decoded into the result register once that is free; the block takes one word every
// cycle while the receiver does not stall. The only loop is the time code state, updated
// as a word is decoded. The four frames-per-second registers (indexes 0 to 3) are written
// through the cfg_ port; the user must write them only while no word is in flight, which
// the block itself does not enforce. Depends on mtc_pkg, mtc_if, mtc_cfg and mtc_track.
module midi_timecode_tracker_core (
  input  logic                          clk,
  input  logic                          rst_n,
  mtc_in_if.sink                        in_ch,
  mtc_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [mtc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mtc_pkg::FPS_W-1:0]     cfg_wdata
);
  import mtc_pkg::*;

  fps_tab_t fps_tab;
  in_word_t in_word;
  in_word_t in_word_r;
  logic     in_valid_r, in_valid_nxt;
  res_t     res;
  res_t     out_res_r;
  logic     out_valid_r, out_valid_nxt;
  logic     out_free;
  logic     in_acc;
  logic     fire;

  // handshake: input register moves into the result register when that frees up
  assign out_free     = !out_valid_r || out_ch.ready;
  assign fire         = in_valid_r && out_free;
  assign in_ch.ready  = !in_valid_r || out_free;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_comb begin
    in_word.func          = in_ch.func;
    in_word.qf_byte       = in_ch.qf_byte;
    in_word.sx_device     = in_ch.sx_device;
    in_word.sx_sub_id1    = in_ch.sx_sub_id1;
    in_word.sx_sub_id2    = in_ch.sx_sub_id2;
    in_word.sx_rate_hours = in_ch.sx_rate_hours;
    in_word.sx_minutes    = in_ch.sx_minutes;
    in_word.sx_seconds    = in_ch.sx_seconds;
    in_word.sx_frames     = in_ch.sx_frames;
  end

  always_comb begin
    in_valid_nxt  = in_acc ? 1'b1 : (fire ? 1'b0 : in_valid_r);
    out_valid_nxt = fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_word_r <= in_word;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  mtc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fps_tab   (fps_tab)
  );

  mtc_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .word    (in_word_r),
    .fps_tab (fps_tab),
    .res     (res)
  );

  // result port
  assign out_ch.valid         = out_valid_r;
  assign out_ch.update_valid  = out_res_r.update_valid;
  assign out_ch.out_frames    = out_res_r.frames;
  assign out_ch.out_seconds   = out_res_r.seconds;
  assign out_ch.out_minutes   = out_res_r.minutes;
  assign out_ch.out_hours     = out_res_r.hours;
  assign out_ch.out_rate      = out_res_r.rate;
  assign out_ch.out_forward   = out_res_r.forward;
  assign out_ch.timer_restart = out_res_r.timer_restart;

endmodule

// ===== rtl/core/mtc_checker.sv =====
// port-level checks for the time code tracker, bound to its top level
// depends on midi_timecode_tracker_core and the channel interfaces
module mtc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [33:0] out_word
);

  logic [1:0] pending_r;
  logic [1:0] pending_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words taken but not yet delivered
  always_comb begin
    pending_nxt = pending_r;
    if (in_acc && !out_acc) begin
      pending_nxt = pending_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      pending_nxt = pending_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // no result without a word behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("result word with no pending input");

  // at most the input and result registers hold words
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != 2'd3)
    else $error("more than two words in flight");

  // an empty result stage never stalls the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while result stage empty");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

endmodule

bind midi_timecode_tracker_core mtc_checker u_mtc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  ({out_ch.update_valid, out_ch.out_frames, out_ch.out_seconds,
               out_ch.out_minutes, out_ch.out_hours, out_ch.out_rate,
               out_ch.out_forward, out_ch.timer_restart})
);

// ===== test/tb.sv =====
// testbench for midi_timecode_tracker_core: random and directed words, per-word prediction
// depends on mtc_pkg and the mtc_in_if / mtc_out_if channel interfaces
`timescale 1ns / 1ps

module tb;
  import mtc_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int unsigned LIMIT_CYCLES = 300000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    in_word_t w;
    bit       drain_first;
  } pending_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FPS_W-1:0]     cfg_wdata = '0;

  mtc_in_if  in_ch ();
  mtc_out_if out_ch ();

  midi_timecode_tracker_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predicted tracker state and frame rate table
  logic [FPS_W-1:0]   rate_fps [NUM_RATES] = '{FPS_RST0, FPS_RST1, FPS_RST2, FPS_RST3};
  logic [NIB_W-1:0]   qf_nib [NUM_PARTS] = '{default: '0};
  logic [PART_W-1:0]  last_part = '0;
  bit                 running_fwd = 1'b0;
  logic [TC_W-1:0]    tc_frm = '0;
  logic [TC_W-1:0]    tc_sec = '0;
  logic [TC_W-1:0]    tc_min = '0;
  logic [HOURS_W-1:0] tc_hrs = '0;
  logic [RATE_W-1:0]  tc_rate = '0;
  logic [TC_W-1:0]    prior_frm = '0;
  logic [TC_W-1:0]    frame_jump = '0;
  logic [TC_W-1:0]    tick_cnt = '0;

  pending_t words_pending [$];
  res_t     times_due [$];
  int       words_queued = 0;
  int       mismatches = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_len = 0;
  logic     recv_hold = 1'b0;
  in_word_t offered;
  pending_t next_word;
  res_t     want;

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // time code after one word, updating the predicted state
  function automatic res_t track_word(input in_word_t w);
    res_t              r;
    logic [PART_W-1:0] part;
    logic [TC_W-1:0]   jmp;
    logic [FPS_W-1:0]  fps;
    r = '0;
    case (w.func)
      KIND_QF: begin
        part = w.qf_byte[6:4];
        qf_nib[part] = w.qf_byte[3:0];
        // direction holds across part 7
        if (part != PART_LAST && last_part != PART_LAST) running_fwd = (last_part < part);
        if ((running_fwd && part == PART_LAST) || (!running_fwd && part == PART_FIRST)) begin
          tc_frm = {qf_nib[1], qf_nib[0]};
          tc_sec = {qf_nib[3], qf_nib[2]};
          tc_min = {qf_nib[5], qf_nib[4]};
          tc_hrs = {qf_nib[7][0], qf_nib[6]};
          tc_rate = qf_nib[7][2:1];
          jmp = (tc_frm < prior_frm) ? prior_frm - tc_frm : tc_frm - prior_frm;
          prior_frm = tc_frm;
          fps = rate_fps[tc_rate];
          if (int'(jmp) + 2 >= int'(fps)) jmp = JUMP_MIN;
          frame_jump = jmp;
          r.update_valid = (tick_cnt < frame_jump);
          r.timer_restart = 1'b1;
          tick_cnt = '0;
        end
        last_part = part;
      end
      KIND_FULL: begin
        if (w.sx_device == SX_DEVICE_ALL && w.sx_sub_id1 == SX_ID_MTC &&
            w.sx_sub_id2 == SX_ID_FULL) begin
          tc_frm = TC_W'(w.sx_frames);
          tc_sec = TC_W'(w.sx_seconds);
          tc_min = TC_W'(w.sx_minutes);
          tc_hrs = w.sx_rate_hours[4:0];
          tc_rate = w.sx_rate_hours[6:5];
          r.update_valid = 1'b1;
          tick_cnt = '0;
        end
      end
      KIND_TICK: begin
        fps = rate_fps[tc_rate];
        if (tick_cnt != TICK_MAX) tick_cnt = tick_cnt + 8'd1;
        if (running_fwd) begin
          // step forward with carry
          tc_frm = tc_frm + 8'd1;
          if (tc_frm == TC_W'(fps)) begin
            tc_frm = '0;
            tc_sec = tc_sec + 8'd1;
            if (tc_sec == SEC_WRAP) begin
              tc_sec = '0;
              tc_min = tc_min + 8'd1;
              if (tc_min == MIN_WRAP) begin
                tc_min = '0;
                tc_hrs = tc_hrs + 5'd1;
                if (tc_hrs == HOUR_WRAP) tc_hrs = '0;
              end
            end
          end
        end else if (tc_frm != '0) begin
          tc_frm = tc_frm - 8'd1;
        end else begin
          // step back with borrow
          tc_frm = TC_W'(fps) - 8'd1;
          if (tc_sec != '0) begin
            tc_sec = tc_sec - 8'd1;
          end else begin
            tc_sec = SEC_LAST;
            if (tc_min != '0) begin
              tc_min = tc_min - 8'd1;
            end else begin
              tc_min = MIN_LAST;
              if (tc_hrs != '0) tc_hrs = tc_hrs - 5'd1;
              else tc_hrs = HOUR_LAST;
            end
          end
        end
        r.update_valid = 1'b1;
        if (frame_jump == JUMP_MIN) begin
          frame_jump = '0;
          r.timer_restart = 1'b1;
        end
      end
      default: ;
    endcase
    r.frames = tc_frm;
    r.seconds = tc_sec;
    r.minutes = tc_min;
    r.hours = tc_hrs;
    r.rate = tc_rate;
    r.forward = running_fwd;
    return r;
  endfunction

  // word builders; unused fields carry random bits
  function automatic in_word_t noise_word();
    logic [63:0] bits;
    in_word_t    w;
    bits = {$urandom, $urandom};
    w = bits[$bits(in_word_t)-1:0];
    return w;
  endfunction

  function automatic in_word_t qf_word(input logic [PART_W-1:0] part,
                                       input logic [NIB_W-1:0] nib);
    in_word_t w;
    w = noise_word();
    w.func = KIND_QF;
    w.qf_byte = {part, nib};
    return w;
  endfunction

  function automatic in_word_t full_word(input logic [SX_W-1:0] dev, id1, id2, rh, m, s, f);
    in_word_t w;
    w = noise_word();
    w.func = KIND_FULL;
    w.sx_device = dev;
    w.sx_sub_id1 = id1;
    w.sx_sub_id2 = id2;
    w.sx_rate_hours = rh;
    w.sx_minutes = m;
    w.sx_seconds = s;
    w.sx_frames = f;
    return w;
  endfunction

  function automatic in_word_t tick_word();
    in_word_t w;
    w = noise_word();
    w.func = KIND_TICK;
    return w;
  endfunction

  function automatic in_word_t unused_word();
    in_word_t w;
    w = noise_word();
    w.func = KIND_UNUSED;
    return w;
  endfunction

  task automatic queue_word(input in_word_t w, input bit drain_first);
    pending_t p;
    p.w = w;
    p.drain_first = drain_first;
    words_pending.push_back(p);
    words_queued++;
  endtask

  // eight quarter frames carrying one time, in either part order
  task automatic queue_frame(input bit dir, input logic [TC_W-1:0] frames);
    logic [NIB_W-1:0]  nib [NUM_PARTS];
    logic [TC_W-1:0]   secs;
    logic [TC_W-1:0]   mins;
    logic [PART_W-1:0] part;
    secs = ($urandom_range(0, 3) == 0) ? TC_W'($urandom) : TC_W'($urandom_range(0, 59));
    mins = ($urandom_range(0, 3) == 0) ? TC_W'($urandom) : TC_W'($urandom_range(0, 59));
    nib[0] = frames[3:0];
    nib[1] = frames[7:4];
    nib[2] = secs[3:0];
    nib[3] = secs[7:4];
    nib[4] = mins[3:0];
    nib[5] = mins[7:4];
    nib[6] = NIB_W'($urandom_range(0, 15));
    nib[7] = NIB_W'($urandom_range(0, 15));
    for (int k = 0; k < NUM_PARTS; k++) begin
      part = dir ? PART_W'(k) : PART_W'(NUM_PARTS - 1 - k);
      queue_word(qf_word(part, nib[part]), 1'b0);
    end
  endtask

  // random traffic, mostly well-formed frame sequences, full-frame messages and ticks
  task automatic queue_random(input int count);
    int goal;
    int pick;
    int f;
    bit dir;
    goal = words_queued + count;
    while (words_queued < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        dir = 1'($urandom_range(0, 1));
        f = $urandom_range(0, 70);
        repeat ($urandom_range(1, 5)) begin
          queue_frame(dir, f[7:0]);
          repeat ($urandom_range(0, 3)) queue_word(tick_word(), 1'b0);
          f = dir ? f + $urandom_range(0, 3) : f - $urandom_range(0, 3);
        end
      end else if (pick < 65) begin
        queue_word(full_word(SX_DEVICE_ALL, SX_ID_MTC, SX_ID_FULL,
                             SX_W'($urandom_range(0, 127)),
                             SX_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                               : $urandom_range(0, 59)),
                             SX_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                               : $urandom_range(0, 59)),
                             SX_W'($urandom_range(0, 127))), 1'b0);
        repeat ($urandom_range(1, 5)) queue_word(tick_word(), 1'b0);
      end else if (pick < 80) begin
        // occasional long run can drive the tick counter into saturation
        if ($urandom_range(0, 5) == 0)
          repeat ($urandom_range(200, 300)) queue_word(tick_word(), 1'b0);
        else
          repeat ($urandom_range(1, 8)) queue_word(tick_word(), 1'b0);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 4))
          queue_word(qf_word(PART_W'($urandom_range(0, 7)), NIB_W'($urandom_range(0, 15))),
                     1'b0);
      end else if (pick < 95) begin
        queue_word(full_word(SX_W'($urandom_range(0, 127)), SX_W'($urandom_range(0, 127)),
                             SX_W'($urandom_range(0, 127)), SX_W'($urandom_range(0, 127)),
                             SX_W'($urandom_range(0, 127)), SX_W'($urandom_range(0, 127)),
                             SX_W'($urandom_range(0, 127))), 1'b0);
      end else begin
        queue_word(unused_word(), 1'b0);
      end
    end
  endtask

  // frame rate registers, written only while idle
  task automatic write_rates(input logic [FPS_W-1:0] r0, r1, r2, r3);
    logic [FPS_W-1:0]     vals [NUM_RATES];
    logic [CFG_IDX_W-1:0] idx [NUM_RATES];
    vals = '{r0, r1, r2, r3};
    idx = '{REG_FPS_RATE0, REG_FPS_RATE1, REG_FPS_RATE2, REG_FPS_RATE3};
    for (int i = 0; i < NUM_RATES; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      rate_fps[i] = vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (words_pending.size() != 0 || in_ch.valid || times_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // driver: offers queued words, predicts each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) times_due.push_back(track_word(offered));
      if (!in_ch.valid || in_ch.ready) begin
        if (words_pending.size() != 0 &&
            !(words_pending[0].drain_first && times_due.size() != 0) &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          next_word = words_pending.pop_front();
          offered = next_word.w;
          in_ch.valid <= 1'b1;
          in_ch.func <= offered.func;
          in_ch.qf_byte <= offered.qf_byte;
          in_ch.sx_device <= offered.sx_device;
          in_ch.sx_sub_id1 <= offered.sx_sub_id1;
          in_ch.sx_sub_id2 <= offered.sx_sub_id2;
          in_ch.sx_rate_hours <= offered.sx_rate_hours;
          in_ch.sx_minutes <= offered.sx_minutes;
          in_ch.sx_seconds <= offered.sx_seconds;
          in_ch.sx_frames <= offered.sx_frames;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each result word with the oldest predicted time code
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (times_due.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual %0d:%0d:%0d:%0d",
                   $time, out_ch.out_hours, out_ch.out_minutes, out_ch.out_seconds,
                   out_ch.out_frames);
          mismatches++;
        end else begin
          want = times_due.pop_front();
          check_field("update_valid", 32'(want.update_valid), 32'(out_ch.update_valid));
          check_field("frames", 32'(want.frames), 32'(out_ch.out_frames));
          check_field("seconds", 32'(want.seconds), 32'(out_ch.out_seconds));
          check_field("minutes", 32'(want.minutes), 32'(out_ch.out_minutes));
          check_field("hours", 32'(want.hours), 32'(out_ch.out_hours));
          check_field("rate", 32'(want.rate), 32'(out_ch.out_rate));
          check_field("forward", 32'(want.forward), 32'(out_ch.out_forward));
          check_field("timer_restart", 32'(want.timer_restart), 32'(out_ch.timer_restart));
        end
      end
      out_ch.ready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off, counted here
  always begin
    @(posedge clk);
    if (hold_len > 0) begin
      recv_hold <= 1'b1;
      repeat (hold_len) @(posedge clk);
      recv_hold <= 1'b0;
      hold_len <= 0;
    end
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = '0;
    in_ch.qf_byte = '0;
    in_ch.sx_device = '0;
    in_ch.sx_sub_id1 = '0;
    in_ch.sx_sub_id2 = '0;
    in_ch.sx_rate_hours = '0;
    in_ch.sx_minutes = '0;
    in_ch.sx_seconds = '0;
    in_ch.sx_frames = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reverse wrap from zero, unused kind, header checks, field extremes
    queue_word(tick_word(), 1'b0);
    queue_word(unused_word(), 1'b0);
    queue_word(full_word(SX_DEVICE_ALL, SX_ID_MTC, SX_ID_FULL, 7'h7F, 7'h7F, 7'h7F, 7'h7F),
               1'b0);
    queue_word(full_word(7'h7E, SX_ID_MTC, SX_ID_FULL, 7'h00, 7'h00, 7'h00, 7'h00), 1'b0);
    queue_word(full_word(SX_DEVICE_ALL, 7'h00, SX_ID_FULL, 7'h00, 7'h00, 7'h00, 7'h00), 1'b0);
    queue_word(full_word(SX_DEVICE_ALL, SX_ID_MTC, 7'h02, 7'h00, 7'h00, 7'h00, 7'h00), 1'b0);
    queue_word(full_word(SX_DEVICE_ALL, SX_ID_MTC, SX_ID_FULL, 7'd23, 7'd59, 7'd59, 7'd0),
               1'b0);
    queue_word(tick_word(), 1'b0);
    // forward parts 0..7 give 23:59:59:23, then a tick wraps everything to zero
    queue_word(qf_word(3'd0, 4'h7), 1'b0);
    queue_word(qf_word(3'd1, 4'h1), 1'b0);
    queue_word(qf_word(3'd2, 4'hB), 1'b0);
    queue_word(qf_word(3'd3, 4'h3), 1'b0);
    queue_word(qf_word(3'd4, 4'hB), 1'b0);
    queue_word(qf_word(3'd5, 4'h3), 1'b0);
    queue_word(qf_word(3'd6, 4'h7), 1'b0);
    queue_word(qf_word(3'd7, 4'h1), 1'b0);
    queue_word(tick_word(), 1'b0);
    // reverse parts 7..0 with all-ones nibbles, direction kept across part 7
    for (int p = NUM_PARTS - 1; p >= 0; p--) queue_word(qf_word(PART_W'(p), 4'hF), 1'b0);
    queue_word(tick_word(), 1'b0);
    queue_random(380);
    wait_drained();

    // extreme rates, sender idling
    write_rates(6'd1, 6'd63, 6'd2, 6'd30);
    send_idle_pct = 49;
    queue_random(360);
    wait_drained();

    // receiver stalling, one pause until everything is out
    write_rates(6'd63, 6'd1, 6'd63, 6'd1);
    send_idle_pct = 0;
    recv_stall_pct = 49;
    queue_random(180);
    queue_word(tick_word(), 1'b1);
    queue_random(180);
    wait_drained();

    // random rates, both sides idling
    write_rates(FPS_W'($urandom_range(1, 63)), FPS_W'($urandom_range(1, 63)),
                FPS_W'($urandom_range(1, 63)), FPS_W'($urandom_range(1, 63)));
    send_idle_pct = 15;
    recv_stall_pct = 15;
    queue_random(360);
    wait_drained();

    // back to default rates, full speed with a long receiver hold-off
    write_rates(FPS_RST0, FPS_RST1, FPS_RST2, FPS_RST3);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random(180);
    queue_word(tick_word(), 1'b1);
    queue_random(180);
    @(posedge clk);
    hold_len <= 400;
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
